// ===== sv/ekvc_pkg.sv =====
package ekvc_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_BITS  = 32;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);

    localparam logic [30:0] EXPIRY_RESET = 31'd60;

    typedef enum logic [2:0] {
        CMD_GET   = 3'd0,
        CMD_SET   = 3'd1,
        CMD_UNSET = 3'd2,
        CMD_TOUCH = 3'd3,
        CMD_PURGE = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic signed [31:0] NEVER_SEEN = -32'sd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input item and run the key match
        logic apply;     // perform the single-result command update
        logic scan_load; // load the purge scan position
        logic scan_step; // examine one slot and advance the scan
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_purge;
        logic scan_evict; // the slot under the scan position is evicted
        logic scan_done;  // the scan position is at the last slot
        logic rest_clear; // no slot after the scan position is evicted
        logic evicted_any;
    } ctrl_sts_t;

endpackage

// ===== sv/expiring_key_value_cache_core.sv =====
// Expiring key/value cache with a 16-slot table. One command is taken per
// input transfer while the block is idle. get, set, unset and touch capture
// the item and match the key against all slots in parallel, then update the
// table and present one result once the output register can take it. purge
// walks the slots one per cycle under the controller, holding at an evicted
// slot while the output is stalled, and presents one result per evicted slot,
// or a single miss result when nothing is evicted. Results sit in an output
// register, and every result carries full and empty flags for the table after
// the whole command.
module expiring_key_value_cache_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        expiry_seconds,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [31:0]        key,
    input  logic [31:0]        data,
    input  logic [30:0]        now,
    input  logic signed [31:0] touch_time,
    input  logic               force_req,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [31:0]        data_out,
    output logic [31:0]        key_out,
    output logic               table_full,
    output logic               table_empty,
    output logic               last
);

    logic [30:0] expiry_reg;
    ekvc_pkg::ctrl_cmd_t cmd;
    ekvc_pkg::ctrl_sts_t sts;
    logic busy, emit, emit_last, emit_miss, in_fire, out_free;
    logic [1:0] r_status;
    logic [31:0] r_data, r_key;
    logic r_full, r_empty;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign in_fire   = in_valid && !busy;
    // The output register can take a new transfer when empty or draining.
    assign out_free  = !out_valid || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expiry_reg <= ekvc_pkg::EXPIRY_RESET;
        else if (cfg_valid && cfg_ready)
            expiry_reg <= expiry_seconds;
    end

    ekvc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_free  (out_free),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .emit      (emit),
        .emit_last (emit_last),
        .emit_miss (emit_miss)
    );

    ekvc_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .command    (command),
        .key        (key),
        .data       (data),
        .now        (now),
        .touch_time (touch_time),
        .force_req  (force_req),
        .expiry     (expiry_reg),
        .sts        (sts),
        .res_status (r_status),
        .res_data   (r_data),
        .res_key    (r_key),
        .res_full   (r_full),
        .res_empty  (r_empty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (emit)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status      <= emit_miss ? ekvc_pkg::ST_MISS : r_status;
            data_out    <= emit_miss ? 32'd0 : r_data;
            key_out     <= emit_miss ? 32'd0 : r_key;
            table_full  <= r_full;
            table_empty <= r_empty;
            last        <= emit_last;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !emit) else $error("result overwritten");
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall) else $error("not busy after transfer");
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> busy) else $error("result while idle");

endmodule

// ===== sv/ekvc_ctrl.sv =====
module ekvc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_free,
    input  ekvc_pkg::ctrl_sts_t sts,
    output ekvc_pkg::ctrl_cmd_t cmd,
    output logic                busy,
    output logic                emit,
    output logic                emit_last,
    output logic                emit_miss
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_NONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        emit          = 1'b0;
        emit_last     = 1'b0;
        emit_miss     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_purge)
                begin
                    cmd.scan_load = 1'b1;
                    state_next    = S_SCAN;
                end
                else if (out_free)
                begin
                    cmd.apply = 1'b1;
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!sts.scan_evict || out_free)
                begin
                    cmd.scan_step = 1'b1;
                    emit          = sts.scan_evict;
                    // The final eviction is the one with no eviction after it.
                    emit_last     = sts.scan_evict && sts.rest_clear;
                    if (sts.scan_done)
                    begin
                        if (sts.scan_evict || sts.evicted_any)
                            state_next = S_IDLE;
                        else
                            state_next = S_NONE;
                    end
                end
            end
            S_NONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_miss  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> state_reg == S_IDLE) else $error("capture while busy");
    a_capture_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_DECIDE) else $error("capture lost");
    a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_last |-> emit) else $error("last without result");

endmodule

// ===== sv/ekvc_datapath.sv =====
module ekvc_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  ekvc_pkg::ctrl_cmd_t cmd,
    input  logic [2:0]          command,
    input  logic [31:0]         key,
    input  logic [31:0]         data,
    input  logic [30:0]         now,
    input  logic signed [31:0]  touch_time,
    input  logic                force_req,
    input  logic [30:0]         expiry,
    output ekvc_pkg::ctrl_sts_t sts,
    output logic [1:0]          res_status,
    output logic [31:0]         res_data,
    output logic [31:0]         res_key,
    output logic                res_full,
    output logic                res_empty
);

    localparam int N = ekvc_pkg::ENTRIES;
    localparam int IB = ekvc_pkg::IDX_BITS;

    logic [N-1:0]                           used_reg;
    logic [N-1:0][ekvc_pkg::KEY_BITS-1:0]   key_reg;
    logic [N-1:0][ekvc_pkg::DATA_BITS-1:0]  data_reg;
    logic [N-1:0][31:0]                     seen_reg;

    logic [2:0]                    cmd_reg;
    logic [ekvc_pkg::KEY_BITS-1:0] key_in_reg;
    logic [ekvc_pkg::DATA_BITS-1:0] data_in_reg;
    logic [30:0]                   now_reg;
    logic signed [31:0]            tt_reg;
    logic                          force_reg;
    logic signed [32:0]            limit_reg;
    logic                          hit_reg;
    logic [IB-1:0]                 hit_idx_reg;
    logic                          free_reg;
    logic [IB-1:0]                 free_idx_reg;
    logic [IB-1:0]                 scan_reg;
    logic                          any_reg;

    logic                 m_hit, m_free;
    logic [IB-1:0]        m_hit_idx, m_free_idx;
    logic [ekvc_pkg::KEY_BITS-1:0] key_m;

    assign key_m = key[ekvc_pkg::KEY_BITS-1:0];

    // Parallel key match and lowest free slot search.
    always_comb
    begin
        m_hit = 1'b0;
        m_hit_idx = '0;
        m_free = 1'b0;
        m_free_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (used_reg[i] && key_reg[i] == key_m)
            begin
                m_hit = 1'b1;
                m_hit_idx = IB'(i);
            end
            if (!used_reg[i])
            begin
                m_free = 1'b1;
                m_free_idx = IB'(i);
            end
        end
    end

    logic signed [32:0] seen_s;
    logic               scan_evict;
    assign seen_s = 33'(signed'(seen_reg[scan_reg]));
    assign scan_evict = used_reg[scan_reg] &&
        (force_reg || (seen_reg[scan_reg] != ekvc_pkg::NEVER_SEEN && seen_s < limit_reg));

    assign sts.is_purge    = (cmd_reg == ekvc_pkg::CMD_PURGE);
    assign sts.scan_evict  = scan_evict;
    assign sts.scan_done   = (scan_reg == IB'(N - 1));
    assign sts.evicted_any = any_reg;

    logic [31:0] now32;
    assign now32 = {1'b0, now_reg};

    // Result fields for the current step; flags come from the state after it.
    logic [N-1:0] used_after;
    always_comb
    begin
        used_after = used_reg;
        res_status = ekvc_pkg::ST_OK;
        res_data   = '0;
        res_key    = '0;
        if (cmd.scan_step)
        begin
            if (scan_evict)
                used_after[scan_reg] = 1'b0;
            res_data = 32'(data_reg[scan_reg]);
            res_key  = 32'(key_reg[scan_reg]);
        end
        else
        begin
            case (cmd_reg)
                ekvc_pkg::CMD_GET:
                begin
                    if (hit_reg) res_data = 32'(data_reg[hit_idx_reg]);
                    else res_status = ekvc_pkg::ST_MISS;
                end
                ekvc_pkg::CMD_SET:
                begin
                    if (hit_reg) res_data = 32'(data_reg[hit_idx_reg]);
                    else if (free_reg) used_after[free_idx_reg] = 1'b1;
                    else res_status = ekvc_pkg::ST_FULL;
                end
                ekvc_pkg::CMD_UNSET:
                begin
                    if (hit_reg)
                    begin
                        res_data = 32'(data_reg[hit_idx_reg]);
                        used_after[hit_idx_reg] = 1'b0;
                    end
                    else res_status = ekvc_pkg::ST_MISS;
                end
                ekvc_pkg::CMD_TOUCH:
                begin
                    if (!hit_reg) res_status = ekvc_pkg::ST_MISS;
                end
                default:
                begin
                    res_status = ekvc_pkg::ST_MISS;
                end
            endcase
        end
    end

    // Purge results are emitted before the rest of the scan, so the flags
    // have to reflect the remaining evictions; a lookahead over the slots
    // after the scan position supplies that.
    logic [N-1:0] rest_evict;
    always_comb
    begin
        for (int i = 0; i < N; i++)
            rest_evict[i] = used_reg[i] && (IB'(i) > scan_reg) && (force_reg ||
                (seen_reg[i] != ekvc_pkg::NEVER_SEEN &&
                 33'(signed'(seen_reg[i])) < limit_reg));
    end

    assign sts.rest_clear = ~|rest_evict;

    logic [N-1:0] final_used;
    assign final_used = cmd.scan_step ? (used_after & ~rest_evict) : used_after;
    assign res_full  = &final_used;
    assign res_empty = ~|final_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            data_reg <= '0;
            seen_reg <= '0;
            cmd_reg  <= '0;
            any_reg  <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                cmd_reg <= command;
                any_reg <= 1'b0;
            end
            if (cmd.scan_load)
                scan_reg <= '0;
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + IB'(1);
                if (scan_evict)
                begin
                    any_reg <= 1'b1;
                    used_reg[scan_reg] <= 1'b0;
                    data_reg[scan_reg] <= '0;
                    seen_reg[scan_reg] <= ekvc_pkg::NEVER_SEEN;
                end
            end
            if (cmd.apply)
            begin
                case (cmd_reg)
                    ekvc_pkg::CMD_GET:
                    begin
                        if (hit_reg && $signed(seen_reg[hit_idx_reg]) < $signed(now32))
                            seen_reg[hit_idx_reg] <= now32;
                    end
                    ekvc_pkg::CMD_SET:
                    begin
                        if (hit_reg)
                        begin
                            data_reg[hit_idx_reg] <= data_in_reg;
                            seen_reg[hit_idx_reg] <= now32;
                        end
                        else if (free_reg)
                        begin
                            used_reg[free_idx_reg] <= 1'b1;
                            data_reg[free_idx_reg] <= data_in_reg;
                            seen_reg[free_idx_reg] <= now32;
                        end
                    end
                    ekvc_pkg::CMD_UNSET:
                    begin
                        if (hit_reg)
                        begin
                            used_reg[hit_idx_reg] <= 1'b0;
                            data_reg[hit_idx_reg] <= '0;
                            seen_reg[hit_idx_reg] <= ekvc_pkg::NEVER_SEEN;
                        end
                    end
                    ekvc_pkg::CMD_TOUCH:
                    begin
                        if (hit_reg)
                            seen_reg[hit_idx_reg] <= (tt_reg <= 0) ? now32 : tt_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_in_reg   <= key_m;
            data_in_reg  <= data[ekvc_pkg::DATA_BITS-1:0];
            now_reg      <= now;
            tt_reg       <= touch_time;
            force_reg    <= force_req;
            limit_reg    <= $signed({2'b00, now}) - $signed({2'b00, expiry});
            hit_reg      <= m_hit;
            hit_idx_reg  <= m_hit_idx;
            free_reg     <= m_free;
            free_idx_reg <= m_free_idx;
        end
        if (cmd.apply && cmd_reg == ekvc_pkg::CMD_SET && !hit_reg && free_reg)
            key_reg[free_idx_reg] <= key_in_reg;
    end

    a_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply && hit_reg |-> used_reg[hit_idx_reg]) else $error("hit on free slot");
    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply && !hit_reg && free_reg && cmd_reg == ekvc_pkg::CMD_SET
        |-> !used_reg[free_idx_reg]) else $error("free slot in use");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_full && res_empty)) else $error("full and empty");

endmodule
